// ===== design/quarter_arc_intersection_top_defines.svh =====
// ----------------------------------------------------------------------------
// quarter_arc_intersection_top_defines
// Assertion macros shared by the quarter arc intersection design.
// ----------------------------------------------------------------------------
`ifndef QUARTER_ARC_INTERSECTION_TOP_DEFINES_SVH
`define QUARTER_ARC_INTERSECTION_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define QAI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent checked against a past value of a fixed depth.
`define QAI_ASSERT_PAST(label, ante, cons, depth) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> $past(cons, depth)) \
    else $error("assertion failed");

`endif

// ===== design/qai_pkg.sv =====
// ----------------------------------------------------------------------------
// qai_pkg
// Types, widths, codes and helper functions of the quarter arc intersection.
// ----------------------------------------------------------------------------
package qai_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int CW          = COORD_WIDTH;
  localparam int QW          = 2 * CW;        // squares, e, quotient
  localparam int D2W         = 2 * CW + 1;    // squared distance
  localparam int NW          = 4 * CW;        // dividend
  localparam int PW          = CW + 2;        // rounded point before saturation
  localparam int LANE_LAT    = 3 * CW + 2;
  localparam int TOTAL_LAT   = LANE_LAT + 7;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  localparam logic [1:0] Q_UR = 2'd0;
  localparam logic [1:0] Q_UL = 2'd1;
  localparam logic [1:0] Q_LL = 2'd2;
  localparam logic [1:0] Q_LR = 2'd3;

  localparam logic [2:0] QCODE_UR = 3'd1;
  localparam logic [2:0] QCODE_UL = 3'd2;
  localparam logic [2:0] QCODE_LL = 3'd3;

  localparam logic signed [PW-1:0] SAT_HI = PW'((2 ** (CW - 1)) - 1);
  localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;

  typedef struct packed {
    logic signed [CW-1:0] center_a_x;
    logic signed [CW-1:0] center_a_y;
    logic [2:0]           quadrant_a;
    logic signed [CW-1:0] center_b_x;
    logic signed [CW-1:0] center_b_y;
    logic [2:0]           quadrant_b;
    logic [CW-2:0]        arc_radius;
  } request_t;

  typedef struct packed {
    logic [1:0]           meet_count;
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
  } result_t;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic [1:0]           qa;
    logic [1:0]           qb;
    logic signed [CW:0]   tx;
    logic signed [CW:0]   ty;
    logic                 dx_pos;
    logic                 dx_neg;
    logic                 dy_pos;
    logic                 dy_neg;
    logic                 same;
    logic [1:0]           same_cnt;
    logic signed [CW:0]   same_px;
    logic signed [CW:0]   same_py;
    logic                 meet;
    logic                 e_zero;
  } side_t;

  function automatic logic [1:0] quad_decode(input logic [2:0] q);
    logic [1:0] r;
    unique case (q)
      QCODE_UR: r = Q_UR;
      QCODE_UL: r = Q_UL;
      QCODE_LL: r = Q_LL;
      default:  r = Q_LR;
    endcase
    return r;
  endfunction

  function automatic logic in_quad(input logic [1:0] q,
                                   input logic signed [CW-1:0] cx,
                                   input logic signed [CW-1:0] cy,
                                   input logic signed [PW-1:0] px,
                                   input logic signed [PW-1:0] py);
    logic xge;
    logic yge;
    logic r;
    xge = px >= PW'(cx);
    yge = py >= PW'(cy);
    unique case (q)
      Q_UR:    r = xge && yge;
      Q_UL:    r = !xge && yge;
      Q_LL:    r = !xge && !yge;
      default: r = xge && !yge;
    endcase
    return r;
  endfunction

  // Halve (t +- root) with ties toward +infinity; floor of a half is a shift.
  function automatic logic signed [PW-1:0] place(input logic signed [CW:0] t,
                                                 input logic [CW-1:0] j,
                                                 input logic ex,
                                                 input logic neg);
    logic signed [CW+2:0] ts;
    logic signed [CW+2:0] js;
    logic signed [CW+2:0] s;
    ts = (CW + 3)'(t);
    js = signed'({3'b000, j});
    if (!neg) begin
      s = ts + js + (CW + 3)'(1);
    end else if (ex) begin
      s = ts + (CW + 3)'(1) - js;
    end else begin
      s = ts - js;
    end
    return signed'(s[CW+2:1]);
  endfunction

  function automatic logic signed [CW-1:0] sat(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] c;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end else begin
      c = v;
    end
    return signed'(c[CW-1:0]);
  endfunction

endpackage

// ===== design/qai_root_lane.sv =====
// ----------------------------------------------------------------------------
// qai_root_lane
// Pipelined floor(sqrt(num / den)) with an exactness flag: restoring division
// one quotient bit a stage, then a digit-by-digit square root one bit a stage.
// ----------------------------------------------------------------------------
module qai_root_lane
  import qai_pkg::*;
(
  input  logic           clk,
  input  logic [NW-1:0]  num,
  input  logic [D2W-1:0] den,
  output logic [CW-1:0]  root,
  output logic           exact
);

  logic [D2W-1:0] drem [0:QW];
  logic [QW-1:0]  dquo [0:QW];
  logic [QW-1:0]  dlow [0:QW];
  logic [D2W-1:0] dden [0:QW];

  logic [CW+1:0]  srem  [0:CW];
  logic [CW-1:0]  sroot [0:CW];
  logic [QW-1:0]  sq    [0:CW];
  logic           sex   [0:CW];

  // the quotient fits QW bits, so the top half of num is already below den
  always_ff @(posedge clk) begin
    drem[0] <= D2W'(num[NW-1:QW]);
    dlow[0] <= num[QW-1:0];
    dquo[0] <= '0;
    dden[0] <= den;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [D2W:0] trial;
    logic         take;
    assign trial = {drem[k], dlow[k][QW-1]};
    assign take  = trial >= {1'b0, dden[k]};
    always_ff @(posedge clk) begin
      drem[k+1] <= take ? D2W'(trial - {1'b0, dden[k]}) : trial[D2W-1:0];
      dquo[k+1] <= {dquo[k][QW-2:0], take};
      dlow[k+1] <= dlow[k] << 1;
      dden[k+1] <= dden[k];
    end
  end

  always_ff @(posedge clk) begin
    srem[0]  <= '0;
    sroot[0] <= '0;
    sq[0]    <= dquo[QW];
    sex[0]   <= drem[QW] == '0;
  end

  for (genvar k = 0; k < CW; k++) begin : g_sqrt
    logic [CW+3:0] t;
    logic [CW+3:0] tr;
    logic          take;
    assign t    = {srem[k], sq[k][QW-1:QW-2]};
    assign tr   = (CW + 4)'({sroot[k], 2'b01});
    assign take = t >= tr;
    always_ff @(posedge clk) begin
      srem[k+1]  <= take ? (CW + 2)'(t - tr) : t[CW+1:0];
      sroot[k+1] <= {sroot[k][CW-2:0], take};
      sq[k+1]    <= sq[k] << 2;
      sex[k+1]   <= sex[k];
    end
  end

  assign root  = sroot[CW];
  assign exact = sex[CW] && (srem[CW] == '0);

endmodule

// ===== design/quarter_arc_intersection_top.sv =====
// ----------------------------------------------------------------------------
// quarter_arc_intersection_top
// Intersection of two equal-radius quarter arcs: count and meeting points.
// ----------------------------------------------------------------------------
// Pipeline: request capture, differences, squares, comparison, partial products, the
// division and square root lanes, rounding, then the registered result and done.
// Throughput: one request per cycle; busy stays low, results are never held.
// Reset: synchronous rst clears every valid bit; data registers keep no reset.
module quarter_arc_intersection_top
  import qai_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

`include "quarter_arc_intersection_top_defines.svh"

  assign busy = 1'b0;

  // stage 1: capture request
  logic     v1;
  request_t req1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    req1 <= request;
  end

  // stage 2: differences, sums, same-center answer
  logic signed [CW:0]   dx;
  logic signed [CW:0]   dy;
  logic signed [CW:0]   adx;
  logic signed [CW:0]   ady;
  logic signed [CW:0]   rr;
  logic [1:0]           pair;
  logic                 nbr;
  side_t                side_b;

  always_comb begin
    side_b     = '0;
    side_b.ax  = req1.center_a_x;
    side_b.ay  = req1.center_a_y;
    side_b.bx  = req1.center_b_x;
    side_b.by  = req1.center_b_y;
    side_b.qa  = quad_decode(req1.quadrant_a);
    side_b.qb  = quad_decode(req1.quadrant_b);
    dx         = (CW + 1)'(req1.center_b_x) - (CW + 1)'(req1.center_a_x);
    dy         = (CW + 1)'(req1.center_b_y) - (CW + 1)'(req1.center_a_y);
    adx        = dx[CW] ? -dx : dx;
    ady        = dy[CW] ? -dy : dy;
    side_b.tx  = (CW + 1)'(req1.center_a_x) + (CW + 1)'(req1.center_b_x);
    side_b.ty  = (CW + 1)'(req1.center_a_y) + (CW + 1)'(req1.center_b_y);
    side_b.dx_neg = dx[CW];
    side_b.dx_pos = !dx[CW] && (dx != '0);
    side_b.dy_neg = dy[CW];
    side_b.dy_pos = !dy[CW] && (dy != '0);
    side_b.same   = (dx == '0) && (dy == '0);
    rr   = signed'({2'b00, req1.arc_radius});
    nbr  = (side_b.qa + 2'd1 == side_b.qb) || (side_b.qb + 2'd1 == side_b.qa);
    pair = (side_b.qa + 2'd1 == side_b.qb) ? side_b.qa : side_b.qb;
    side_b.same_px = (CW + 1)'(req1.center_a_x);
    side_b.same_py = (CW + 1)'(req1.center_a_y);
    if (side_b.qa == side_b.qb) begin
      side_b.same_cnt = CNT_INF;
    end else if (nbr) begin
      side_b.same_cnt = CNT_ONE;
      unique case (pair)
        Q_UR:    side_b.same_py = (CW + 1)'(req1.center_a_y) + rr;
        Q_UL:    side_b.same_px = (CW + 1)'(req1.center_a_x) - rr;
        Q_LL:    side_b.same_py = (CW + 1)'(req1.center_a_y) - rr;
        default: side_b.same_px = (CW + 1)'(req1.center_a_x) + rr;
      endcase
    end else begin
      side_b.same_cnt = CNT_NONE;
    end
  end

  logic          v2;
  side_t         side2;
  logic [CW-1:0] mx2;
  logic [CW-1:0] my2;
  logic [CW-2:0] r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    side2 <= side_b;
    mx2   <= adx[CW-1:0];
    my2   <= ady[CW-1:0];
    r2    <= req1.arc_radius;
  end

  // stage 3: squares
  logic          v3;
  side_t         side3;
  logic [QW-1:0] dx2_3;
  logic [QW-1:0] dy2_3;
  logic [QW-3:0] rsq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    side3 <= side2;
    dx2_3 <= mx2 * mx2;
    dy2_3 <= my2 * my2;
    rsq3  <= r2 * r2;
  end

  // stage 4: distance against diameter
  logic [D2W-1:0] d2_c;
  logic [QW-1:0]  r4_c;
  side_t          side_d;

  always_comb begin
    d2_c   = {1'b0, dx2_3} + {1'b0, dy2_3};
    r4_c   = {rsq3, 2'b00};
    side_d = side3;
    side_d.meet   = d2_c <= {1'b0, r4_c};
    side_d.e_zero = d2_c == {1'b0, r4_c};
  end

  logic           v4;
  side_t          side4;
  logic [D2W-1:0] d2_4;
  logic [QW-1:0]  e4;
  logic [QW-1:0]  dx2_4;
  logic [QW-1:0]  dy2_4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    side4 <= side_d;
    d2_4  <= d2_c;
    e4    <= r4_c - d2_c[QW-1:0];
    dx2_4 <= dx2_3;
    dy2_4 <= dy2_3;
  end

  // stage 5: partial products of comp2 * e
  logic [QW-1:0]  xhh, xhl, xlh, xll;
  logic [QW-1:0]  yhh, yhl, ylh, yll;
  logic [D2W-1:0] d2_5;
  side_t          sl [0:LANE_LAT];
  logic           vl [0:LANE_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vl[0] <= 1'b0;
    end else begin
      vl[0] <= v4;
    end
    sl[0] <= side4;
    d2_5  <= d2_4;
    xhh   <= dy2_4[QW-1:CW] * e4[QW-1:CW];
    xhl   <= dy2_4[QW-1:CW] * e4[CW-1:0];
    xlh   <= dy2_4[CW-1:0] * e4[QW-1:CW];
    xll   <= dy2_4[CW-1:0] * e4[CW-1:0];
    yhh   <= dx2_4[QW-1:CW] * e4[QW-1:CW];
    yhl   <= dx2_4[QW-1:CW] * e4[CW-1:0];
    ylh   <= dx2_4[CW-1:0] * e4[QW-1:CW];
    yll   <= dx2_4[CW-1:0] * e4[CW-1:0];
  end

  logic [NW-1:0] nx;
  logic [NW-1:0] ny;

  assign nx = (NW'(xhh) << QW) + ((NW'(xhl) + NW'(xlh)) << CW) + NW'(xll);
  assign ny = (NW'(yhh) << QW) + ((NW'(yhl) + NW'(ylh)) << CW) + NW'(yll);

  logic [CW-1:0] jx, jy;
  logic          ex, ey;

  qai_root_lane u_lane_x (
    .clk   (clk),
    .num   (nx),
    .den   (d2_5),
    .root  (jx),
    .exact (ex)
  );

  qai_root_lane u_lane_y (
    .clk   (clk),
    .num   (ny),
    .den   (d2_5),
    .root  (jy),
    .exact (ey)
  );

  // hold side data alongside the root lanes
  for (genvar k = 1; k <= LANE_LAT; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k] <= 1'b0;
      end else begin
        vl[k] <= vl[k-1];
      end
      sl[k] <= sl[k-1];
    end
  end

  // stage 6: round the candidate points
  logic                 v6;
  side_t                side6;
  logic signed [PW-1:0] p1x, p1y, p2x, p2y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= vl[LANE_LAT];
    end
    side6 <= sl[LANE_LAT];
    p1x   <= place(sl[LANE_LAT].tx, jx, ex, sl[LANE_LAT].dy_pos);
    p2x   <= place(sl[LANE_LAT].tx, jx, ex, sl[LANE_LAT].dy_neg);
    p1y   <= place(sl[LANE_LAT].ty, jy, ey, sl[LANE_LAT].dx_neg);
    p2y   <= place(sl[LANE_LAT].ty, jy, ey, sl[LANE_LAT].dx_pos);
  end

  // stage 7: quadrant tests, count, saturate
  logic                 ok1, ok2;
  logic [1:0]           cnt;
  logic signed [PW-1:0] fx, fy;
  result_t              res_c;

  always_comb begin
    ok1 = in_quad(side6.qa, side6.ax, side6.ay, p1x, p1y)
          && in_quad(side6.qb, side6.bx, side6.by, p1x, p1y);
    ok2 = in_quad(side6.qa, side6.ax, side6.ay, p2x, p2y)
          && in_quad(side6.qb, side6.bx, side6.by, p2x, p2y);
    fx  = p1x;
    fy  = p1y;
    priority if (side6.same) begin
      cnt = side6.same_cnt;
      fx  = PW'(side6.same_px);
      fy  = PW'(side6.same_py);
    end else if (!side6.meet) begin
      cnt = CNT_NONE;
    end else if (side6.e_zero) begin
      cnt = ok1 ? CNT_ONE : CNT_NONE;
    end else if (ok1 && ok2) begin
      cnt = CNT_TWO;
    end else if (ok1) begin
      cnt = CNT_ONE;
    end else if (ok2) begin
      cnt = CNT_ONE;
      fx  = p2x;
      fy  = p2y;
    end else begin
      cnt = CNT_NONE;
    end
    res_c.meet_count = cnt;
    if (cnt == CNT_ONE || cnt == CNT_TWO) begin
      res_c.first_x = sat(fx);
      res_c.first_y = sat(fy);
    end else begin
      res_c.first_x = '0;
      res_c.first_y = '0;
    end
    if (cnt == CNT_TWO) begin
      res_c.second_x = sat(p2x);
      res_c.second_y = sat(p2y);
    end else begin
      res_c.second_x = '0;
      res_c.second_y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v6;
    end
    result <= res_c;
  end

  logic no_point;
  logic not_two;

  assign no_point = (result.meet_count == CNT_NONE) || (result.meet_count == CNT_INF);
  assign not_two  = result.meet_count != CNT_TWO;

  `QAI_ASSERT_PAST(a_done_traces_request, done, start && !busy, TOTAL_LAT)
  `QAI_ASSERT_IMPL(a_first_zero, done && no_point, {result.first_x, result.first_y} == '0)
  `QAI_ASSERT_IMPL(a_second_zero, done && not_two, {result.second_x, result.second_y} == '0)

endmodule
